### hdl/rv32s_pkg.sv
// Shared constants, codes and types of the RV32 subset instruction step core.
package rv32s_pkg;

	// Size of the byte data memory.
	localparam int unsigned MEM_BYTES = 65536;

	// The data memory is split into four byte banks, one per byte lane of a word.
	localparam int unsigned BANKS    = 4;
	localparam int unsigned MEM_ROWS = (MEM_BYTES + BANKS - 1) / BANKS;
	localparam int unsigned ROW_W    = $clog2(MEM_ROWS);

	// A word access is legal when its last byte address is below this limit.
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
	localparam logic [32:0] WORD_LAST = 33'd3;

	localparam logic [31:0] PC_STEP = 32'd4;

	typedef logic [31:0] word_t;
	typedef logic [4:0]  reg_idx_t;
	typedef logic [7:0]  byte_t;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_AND     = 4'd2,
		OP_OR      = 4'd3,
		OP_XOR     = 4'd4,
		OP_SLL     = 4'd5,
		OP_SRL     = 4'd6,
		OP_LW      = 4'd7,
		OP_SW      = 4'd8,
		OP_BEQ     = 4'd9,
		OP_BNE     = 4'd10,
		OP_BLT     = 4'd11,
		OP_JAL     = 4'd12,
		OP_ECALL   = 4'd13,
		OP_NOP     = 4'd14,
		OP_INVALID = 4'd15
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_HALTED   = 2'd1,
		STS_BAD_ADDR = 2'd2,
		STS_BAD_OP   = 2'd3
	} status_t;

endpackage

### hdl/rv32s_instr_if.sv
// Instruction channel: one decoded instruction per beat.
interface rv32s_instr_if;
	import rv32s_pkg::*;

	logic                valid;
	logic                ready;
	opcode_t             opcode;
	reg_idx_t            dest_reg;
	reg_idx_t            src1_reg;
	reg_idx_t            src2_reg;
	logic signed [11:0]  offset;

	modport source (output valid, output opcode, output dest_reg, output src1_reg,
		output src2_reg, output offset, input ready);
	modport sink (input valid, input opcode, input dest_reg, input src1_reg,
		input src2_reg, input offset, output ready);
endinterface

### hdl/rv32s_result_if.sv
// Result channel: the outcome of one instruction per beat.
interface rv32s_result_if;
	import rv32s_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	word_t   pc_after;
	logic    skip_next;
	logic    halted_now;
	logic    reg_written;
	word_t   written_value;

	modport source (output valid, output status, output pc_after, output skip_next,
		output halted_now, output reg_written, output written_value, input ready);
	modport sink (input valid, input status, input pc_after, input skip_next,
		input halted_now, input reg_written, input written_value, output ready);
endinterface

### hdl/rv32_subset_instruction_step_core.sv
// Top level of the RV32 subset instruction step core: register file, data memory, sequencer.
//
//   channel  direction  modport  what one beat carries
//   instr    in         sink     opcode, dest_reg, src1_reg, src2_reg, offset
//   result   out        source   status, pc_after, skip_next, halted_now,
//                                reg_written, written_value
//
// An instruction passes through accept, execute and retire; lw and sw add a data memory
// access between execute and retire, and retiring waits while the output register is full.
// The register file is read in the accept cycle and the data memory read is registered.
// After reset the data memory is cleared one row (four bytes) a cycle, through all MEM_ROWS
// rows (16384 at the default size); instr.ready stays low meanwhile.
// A result waits in the output register while the next instruction is taken; only
// retiring stalls when that register is still full.

module rv32_subset_instruction_step_core (
	input logic             clk,
	input logic             arst_n,
	rv32s_instr_if.sink     instr,
	rv32s_result_if.source  result
);
	import rv32s_pkg::*;

	// The sequencer walks each instruction through its phases. CLEAR zeroes the
	// data memory after reset.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MEM,
		S_DONE
	} state_t;

	state_t state_q;

	// Architectural state held in flip-flops.
	word_t pc_q;
	logic  halt_q;

	// Register file: a 32-entry memory with two registered read ports. A valid bit
	// per entry stands in for the zero reset; x0 is never written, so it reads zero.
	word_t           rf_mem [32];
	logic [31:0]     rf_vld_q;
	word_t           rf_a_q;
	word_t           rf_b_q;
	logic            rf_a_vld_q;
	logic            rf_b_vld_q;
	reg_idx_t        rf_b_addr;
	logic            rf_we;

	// The instruction as captured at accept.
	opcode_t             op_q;
	reg_idx_t            rd_q;
	logic signed [11:0]  off_q;

	// Outcome of the execute phase.
	status_t     res_status_q;
	word_t       res_val_q;
	word_t       res_pc_q;
	logic        res_wr_q;
	logic        res_skip_q;
	logic        res_halt_q;
	word_t       addr_q;
	word_t       st_data_q;

	// Output register.
	logic    out_valid_q;
	status_t out_status_q;
	word_t   out_pc_q;
	logic    out_skip_q;
	logic    out_halt_q;
	logic    out_wr_q;
	word_t   out_val_q;

	// Clearing pass row counter.
	logic [ROW_W-1:0] clr_row_q;

	// Data memory bank ports.
	logic [ROW_W-1:0] bank_row   [BANKS];
	byte_t            bank_wdata [BANKS];
	byte_t            bank_rdata [BANKS];
	logic             bank_we;
	logic             bank_re;

	logic accept;
	logic out_free;
	logic retire;

	assign instr.ready = (state_q == S_IDLE);
	assign accept      = instr.valid && (state_q == S_IDLE);
	assign out_free    = !out_valid_q || result.ready;
	assign retire      = (state_q == S_DONE) && out_free;

	// Port B serves the store data for sw and the second operand otherwise.
	assign rf_b_addr = (instr.opcode == OP_SW) ? instr.dest_reg : instr.src2_reg;

	// ------------------------------------------------------------------
	// Execute: operands, ALU, branch compare and the effective address.
	// ------------------------------------------------------------------
	word_t    op_a;
	word_t    op_b;
	word_t    eff_addr;
	logic     in_range;
	word_t    pc_inc;
	status_t  x_status;
	word_t    x_val;
	logic     x_writes;
	logic     x_skip;
	logic     x_halt_set;
	logic     x_mem;
	logic     x_ok;

	assign op_a     = rf_a_vld_q ? rf_a_q : '0;
	assign op_b     = rf_b_vld_q ? rf_b_q : '0;
	assign eff_addr = op_a + {{20{off_q[11]}}, off_q};
	assign in_range = ({1'b0, eff_addr} + WORD_LAST) < MEM_LIMIT;
	assign pc_inc   = pc_q + PC_STEP;

	always_comb begin
		x_status   = STS_OK;
		x_val      = '0;
		x_writes   = 1'b0;
		x_skip     = 1'b0;
		x_halt_set = 1'b0;
		x_mem      = 1'b0;
		if (halt_q) begin
			x_status = STS_HALTED;
		end else begin
			unique case (op_q)
				OP_ADD: begin
					x_val    = op_a + op_b;
					x_writes = 1'b1;
				end
				OP_SUB: begin
					x_val    = op_a - op_b;
					x_writes = 1'b1;
				end
				OP_AND: begin
					x_val    = op_a & op_b;
					x_writes = 1'b1;
				end
				OP_OR: begin
					x_val    = op_a | op_b;
					x_writes = 1'b1;
				end
				OP_XOR: begin
					x_val    = op_a ^ op_b;
					x_writes = 1'b1;
				end
				OP_SLL: begin
					x_val    = op_a << op_b[4:0];
					x_writes = 1'b1;
				end
				OP_SRL: begin
					x_val    = op_a >> op_b[4:0];
					x_writes = 1'b1;
				end
				OP_LW: begin
					if (in_range) begin
						x_writes = 1'b1;
						x_mem    = 1'b1;
					end else begin
						x_status = STS_BAD_ADDR;
					end
				end
				OP_SW: begin
					if (in_range) begin
						x_mem = 1'b1;
					end else begin
						x_status = STS_BAD_ADDR;
					end
				end
				OP_BEQ:   x_skip = (op_a == op_b);
				OP_BNE:   x_skip = (op_a != op_b);
				OP_BLT:   x_skip = ($signed(op_a) < $signed(op_b));
				OP_JAL: begin
					x_val    = pc_inc;
					x_writes = 1'b1;
				end
				OP_ECALL: x_halt_set = 1'b1;
				OP_NOP:   x_halt_set = 1'b0;
				OP_INVALID: x_status = STS_BAD_OP;
				default:  x_status = STS_BAD_OP;
			endcase
		end
		x_ok = (x_status == STS_OK);
	end

	// ------------------------------------------------------------------
	// Data memory: four byte banks. A word at any byte address touches each
	// bank once; banks below the low address bits take the next row.
	// ------------------------------------------------------------------
	logic [1:0]        lo;
	logic [ROW_W-1:0]  base_row;
	word_t             ld_word;

	assign lo       = addr_q[1:0];
	assign base_row = addr_q[ROW_W+1:2];
	assign bank_we  = (state_q == S_CLEAR) || ((state_q == S_MEM) && (op_q == OP_SW));
	assign bank_re  = (state_q == S_MEM) && (op_q == OP_LW);

	always_comb begin
		logic [1:0] lane;
		word_t      shifted;
		for (int k = 0; k < BANKS; k++) begin
			lane    = 2'(k) - lo;
			shifted = st_data_q >> {lane, 3'b000};
			if (state_q == S_CLEAR) begin
				bank_row[k]   = clr_row_q;
				bank_wdata[k] = '0;
			end else begin
				bank_row[k]   = base_row + ROW_W'(2'(k) < lo);
				bank_wdata[k] = shifted[7:0];
			end
		end
	end

	for (genvar k = 0; k < BANKS; k++) begin : g_bank
		byte_t bank_mem [MEM_ROWS];

		always_ff @(posedge clk) begin
			if (bank_we) begin
				bank_mem[bank_row[k]] <= bank_wdata[k];
			end
			if (bank_re) begin
				bank_rdata[k] <= bank_mem[bank_row[k]];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			ld_word[8*i +: 8] = bank_rdata[2'(2'(i) + lo)];
		end
	end

	// Value that retires: loads take the assembled word, everything else the ALU result.
	function automatic word_t out_val_next();
		word_t v;
		if (op_q == OP_LW) begin
			v = res_wr_q ? ld_word : '0;
		end else begin
			v = res_val_q;
		end
		return v;
	endfunction

	assign rf_we = retire && res_wr_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rf_a_q <= rf_mem[instr.src1_reg];
			rf_b_q <= rf_mem[rf_b_addr];
		end
		if (rf_we) begin
			rf_mem[rd_q] <= out_val_next();
		end
	end

	// ------------------------------------------------------------------
	// Sequencer, architectural state and the output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_row_q    <= '0;
			pc_q         <= '0;
			halt_q       <= 1'b0;
			rf_vld_q     <= '0;
			rf_a_vld_q   <= 1'b0;
			rf_b_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			op_q         <= OP_NOP;
			rd_q         <= '0;
			off_q        <= '0;
			res_status_q <= STS_OK;
			res_val_q    <= '0;
			res_pc_q     <= '0;
			res_wr_q     <= 1'b0;
			res_skip_q   <= 1'b0;
			res_halt_q   <= 1'b0;
			addr_q       <= '0;
			st_data_q    <= '0;
			out_status_q <= STS_OK;
			out_pc_q     <= '0;
			out_skip_q   <= 1'b0;
			out_halt_q   <= 1'b0;
			out_wr_q     <= 1'b0;
			out_val_q    <= '0;
		end else begin
			// A retiring beat refills the output register; otherwise a taken beat empties it.
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == ROW_W'(MEM_ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q       <= instr.opcode;
						rd_q       <= instr.dest_reg;
						off_q      <= instr.offset;
						rf_a_vld_q <= rf_vld_q[instr.src1_reg];
						rf_b_vld_q <= rf_vld_q[rf_b_addr];
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= x_status;
					res_wr_q     <= x_ok && x_writes && (rd_q != '0);
					res_val_q    <= (x_ok && x_writes && (rd_q != '0)) ? x_val : '0;
					res_skip_q   <= x_ok && x_skip;
					res_halt_q   <= halt_q || (x_ok && x_halt_set);
					res_pc_q     <= x_ok ? pc_inc : pc_q;
					addr_q       <= eff_addr;
					st_data_q    <= op_b;
					state_q      <= x_mem ? S_MEM : S_DONE;
				end
				S_MEM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_pc_q     <= res_pc_q;
						out_skip_q   <= res_skip_q;
						out_halt_q   <= res_halt_q;
						out_wr_q     <= res_wr_q;
						out_val_q    <= out_val_next();
						pc_q         <= res_pc_q;
						halt_q       <= res_halt_q;
						if (res_wr_q) begin
							rf_vld_q[rd_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.pc_after      = out_pc_q;
	assign result.skip_next     = out_skip_q;
	assign result.halted_now    = out_halt_q;
	assign result.reg_written   = out_wr_q;
	assign result.written_value = out_val_q;

endmodule

### dv/rv32_subset_instruction_step_core_tb.sv
// Self-checking testbench of the RV32 subset instruction step core.
module rv32_subset_instruction_step_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rv32s_pkg::*;

	// Cycles with no beat on either channel before the run is declared hung. The limit sits
	// well above the length of the data memory clear after reset.
	localparam int unsigned STUCK_LIMIT = 4 * MEM_ROWS + 20000;
	// Length of the long receiver hold-off that makes the core back up into its input.
	localparam int unsigned HOLD_CYCLES = 300;
	// Random instructions per idling phase.
	localparam int unsigned PHASE_ITEMS = 300;
	// Quiet cycles after the last result, so that a stray extra result is still caught.
	localparam int unsigned DRAIN_CYCLES = 24;

	// One instruction as it travels on the instruction channel.
	typedef struct {
		opcode_t            op;
		reg_idx_t           rd;
		reg_idx_t           rs1;
		reg_idx_t           rs2;
		logic signed [11:0] off;
	} instr_beat_t;

	// One outcome as it travels on the result channel.
	typedef struct {
		status_t status;
		word_t   pc_after;
		logic    skip_next;
		logic    halted_now;
		logic    reg_written;
		word_t   written_value;
	} outcome_t;

	// Architectural shadow of the core plus the queue of outcomes still owed by the DUT.
	class instr_step_predictor;
		word_t    regs [32];
		byte_t    mem [MEM_BYTES];
		word_t    pc;
		logic     halted;
		outcome_t pending_outcomes [$];
		int       errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			pc = '0;
			halted = 1'b0;
			errors = 0;
		endfunction

		// Executes one accepted instruction on the shadow state and queues its outcome.
		function void note_instr(instr_beat_t b);
			word_t       a;
			word_t       c;
			word_t       addr;
			word_t       val;
			word_t       store_word;
			logic        wr;
			logic        skip;
			logic        addr_ok;
			status_t     sts;
			outcome_t    o;

			a = regs[b.rs1];
			c = regs[b.rs2];
			addr = a + {{20{b.off[11]}}, b.off};
			// The last byte of the word is checked with one extra bit, so a wrap past
			// the top of the address space reads as out of range.
			addr_ok = ({1'b0, addr} + 33'd3) < 33'(MEM_BYTES);
			val = '0;
			wr = 1'b0;
			skip = 1'b0;
			sts = STS_OK;

			if (halted) begin
				sts = STS_HALTED;
			end else begin
				case (b.op)
					OP_ADD: begin val = a + c; wr = 1'b1; end
					OP_SUB: begin val = a - c; wr = 1'b1; end
					OP_AND: begin val = a & c; wr = 1'b1; end
					OP_OR:  begin val = a | c; wr = 1'b1; end
					OP_XOR: begin val = a ^ c; wr = 1'b1; end
					OP_SLL: begin val = a << c[4:0]; wr = 1'b1; end
					OP_SRL: begin val = a >> c[4:0]; wr = 1'b1; end
					OP_LW: begin
						if (!addr_ok) begin
							sts = STS_BAD_ADDR;
						end else begin
							val = {mem[addr + 3], mem[addr + 2], mem[addr + 1], mem[addr]};
							wr = 1'b1;
						end
					end
					OP_SW: begin
						if (!addr_ok) begin
							sts = STS_BAD_ADDR;
						end else begin
							// The store data comes from the destination field.
							store_word = regs[b.rd];
							mem[addr]     = store_word[7:0];
							mem[addr + 1] = store_word[15:8];
							mem[addr + 2] = store_word[23:16];
							mem[addr + 3] = store_word[31:24];
						end
					end
					OP_BEQ: skip = (a == c);
					OP_BNE: skip = (a != c);
					OP_BLT: skip = ($signed(a) < $signed(c));
					OP_JAL: begin val = pc + PC_STEP; wr = 1'b1; end
					OP_ECALL: halted = 1'b1;
					OP_NOP: ;
					default: sts = STS_BAD_OP;
				endcase
				if (sts == STS_OK) begin
					if (wr && b.rd != '0) regs[b.rd] = val;
					pc = pc + PC_STEP;
				end
			end

			o.status        = sts;
			o.pc_after      = pc;
			o.skip_next     = (sts == STS_OK) ? skip : 1'b0;
			o.halted_now    = halted;
			o.reg_written   = (sts == STS_OK) && wr && (b.rd != '0);
			o.written_value = o.reg_written ? val : '0;
			pending_outcomes.push_back(o);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
				errors++;
			end
		endfunction

		// Compares one result beat with the oldest outstanding outcome.
		function void check_outcome(outcome_t got);
			outcome_t want;

			if (pending_outcomes.size() == 0) begin
				$error("result beat with no instruction outstanding");
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("pc_after", want.pc_after, got.pc_after);
			compare_field("skip_next", 32'(want.skip_next), 32'(got.skip_next));
			compare_field("halted_now", 32'(want.halted_now), 32'(got.halted_now));
			compare_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
			compare_field("written_value", want.written_value, got.written_value);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rv32s_instr_if  instr_bus ();
	rv32s_result_if result_bus ();

	rv32_subset_instruction_step_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_bus),
		.result (result_bus)
	);

	instr_step_predictor predictor;

	// Idling knobs, in percent, changed by the stimulus process at phase boundaries.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	// Raised by the stimulus process to ask the receiver for one long hold-off.
	bit          hold_req;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Result channel receiver. Ready is redrawn every cycle from the current stall rate,
	// except during the requested hold-off, where it is held low for a counted stretch
	// while the sender keeps offering beats.
	initial begin
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every result beat is checked against the predicted outcome queue.
	always @(posedge clk) begin
		outcome_t got;

		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.status        = result_bus.status;
			got.pc_after      = result_bus.pc_after;
			got.skip_next     = result_bus.skip_next;
			got.halted_now    = result_bus.halted_now;
			got.reg_written   = result_bus.reg_written;
			got.written_value = result_bus.written_value;
			predictor.check_outcome(got);
		end
	end

	// Watchdog: any beat on either channel restarts the count. It also covers the memory
	// clear after reset, during which the core accepts nothing.
	initial begin
		int unsigned stuck;

		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((instr_bus.valid && instr_bus.ready) ||
					(result_bus.valid && result_bus.ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("rv32_subset_instruction_step_core regression: fail");
		$finish;
	end

	function automatic instr_beat_t make_instr(opcode_t op, int rd, int rs1, int rs2,
			int off);
		instr_beat_t b;

		b.op  = op;
		b.rd  = reg_idx_t'(rd);
		b.rs1 = reg_idx_t'(rs1);
		b.rs2 = reg_idx_t'(rs2);
		b.off = 12'(off);
		return b;
	endfunction

	// Draws one random instruction. ecall is never drawn, since a halt would turn every
	// later beat into a plain halted report; the run ends with one on purpose instead.
	// Loads and stores mostly aim at valid addresses, with a share placed right at the
	// top of memory and the rest left fully random.
	function automatic instr_beat_t random_instr();
		instr_beat_t b;
		int unsigned pick;
		longint      base;
		longint      lo;
		longint      hi;
		longint      target;

		b.rd  = reg_idx_t'($urandom);
		b.rs1 = reg_idx_t'($urandom);
		b.rs2 = reg_idx_t'($urandom);
		b.off = 12'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)
			b.op = OP_JAL;
		else if (pick < 50)
			b.op = opcode_t'($urandom_range(OP_SRL, OP_ADD));
		else if (pick < 76)
			b.op = $urandom_range(1) ? OP_LW : OP_SW;
		else if (pick < 90)
			b.op = opcode_t'($urandom_range(OP_BLT, OP_BEQ));
		else if (pick < 94)
			b.op = OP_NOP;
		else if (pick < 97)
			b.op = OP_INVALID;
		else
			b.op = opcode_t'($urandom_range(15));
		if (b.op == OP_ECALL) b.op = OP_NOP;

		// Equal operands make the equality branch fire often enough to matter.
		if ((b.op == OP_BEQ || b.op == OP_BNE) && $urandom_range(2) == 0) b.rs2 = b.rs1;

		if (b.op == OP_LW || b.op == OP_SW) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				b.rs1 = '0;
				b.off = 12'($urandom_range(2047));
			end else if (pick < 85) begin
				base = predictor.regs[b.rs1];
				lo = (base > 2048) ? base - 2048 : 0;
				hi = base + 2047;
				if (hi > MEM_BYTES - 4) hi = MEM_BYTES - 4;
				if (lo <= hi) begin
					if (hi == MEM_BYTES - 4 && $urandom_range(3) == 0)
						target = hi + $urandom_range(3);
					else
						target = lo + $urandom_range(int'(hi - lo));
					// A target near the top word may lie up to three bytes past what the offset can reach from here.
					if (target - base <= 2047) b.off = 12'(target - base);
				end
			end
		end
		return b;
	endfunction

	// Offers one instruction beat, with random idle cycles before it, and hands it to the
	// predictor once it has been accepted. Called and returning at a rising edge.
	task automatic send_instr(instr_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			instr_bus.valid <= 1'b0;
			@(posedge clk);
		end
		instr_bus.valid    <= 1'b1;
		instr_bus.opcode   <= b.op;
		instr_bus.dest_reg <= b.rd;
		instr_bus.src1_reg <= b.rs1;
		instr_bus.src2_reg <= b.rs2;
		instr_bus.offset   <= b.off;
		@(posedge clk);
		while (!instr_bus.ready) @(posedge clk);
		predictor.note_instr(b);
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) send_instr(random_instr());
	endtask

	initial begin
		instr_beat_t directed [$];

		predictor = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		arst_n = 1'b0;
		instr_bus.valid    <= 1'b0;
		instr_bus.opcode   <= OP_NOP;
		instr_bus.dest_reg <= '0;
		instr_bus.src1_reg <= '0;
		instr_bus.src2_reg <= '0;
		instr_bus.offset   <= '0;
		repeat (2) @(posedge clk);
		// Release away from the rising edge so the core sees a clean reset exit.
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed part. The register file starts at zero and jal is the only way to
		// create a nonzero value, so the sequence first builds 4 and 8, then shifts and
		// adds its way up to 65536 to reach the very top word of memory.
		directed.push_back(make_instr(OP_JAL, 1, 0, 0, 0));        // x1 = 4
		directed.push_back(make_instr(OP_JAL, 31, 31, 31, -1));    // x31 = 8
		directed.push_back(make_instr(OP_SLL, 2, 1, 1, 0));        // x2 = 64
		directed.push_back(make_instr(OP_SLL, 3, 2, 1, 0));        // x3 = 1024
		directed.push_back(make_instr(OP_SLL, 4, 3, 1, 0));        // x4 = 16384
		directed.push_back(make_instr(OP_ADD, 4, 4, 4, 0));        // x4 = 32768
		directed.push_back(make_instr(OP_ADD, 4, 4, 4, 0));        // x4 = 65536
		directed.push_back(make_instr(OP_SUB, 6, 0, 1, 0));        // x6 = -4
		// Store into the last word of memory, read it back, then one byte too far.
		directed.push_back(make_instr(OP_SW, 6, 4, 0, -4));
		directed.push_back(make_instr(OP_LW, 7, 4, 0, -4));
		directed.push_back(make_instr(OP_SW, 6, 4, 0, -3));
		// A base near the top of the address space plus a positive offset wraps to a
		// low, valid address; a negative offset from x0 wraps high and is rejected.
		directed.push_back(make_instr(OP_SW, 6, 6, 0, 2047));
		directed.push_back(make_instr(OP_LW, 9, 0, 0, -2048));
		directed.push_back(make_instr(OP_LW, 10, 6, 0, 2044));     // straddles the store
		// Shift amounts use only the low five bits of the second source.
		directed.push_back(make_instr(OP_SRL, 11, 6, 31, 0));
		directed.push_back(make_instr(OP_SLL, 12, 1, 6, 0));
		directed.push_back(make_instr(OP_AND, 13, 6, 11, 0));
		directed.push_back(make_instr(OP_OR, 14, 12, 11, 0));
		directed.push_back(make_instr(OP_XOR, 15, 6, 12, 0));
		directed.push_back(make_instr(OP_BEQ, 0, 1, 1, 0));
		directed.push_back(make_instr(OP_BNE, 0, 1, 31, 0));
		directed.push_back(make_instr(OP_BLT, 0, 6, 1, 0));        // signed: -4 < 4
		directed.push_back(make_instr(OP_BLT, 0, 1, 6, 0));
		// A write to x0 is dropped and not reported.
		directed.push_back(make_instr(OP_ADD, 0, 1, 1, 0));
		directed.push_back(make_instr(OP_NOP, 31, 31, 31, 2047));
		directed.push_back(make_instr(OP_INVALID, 31, 31, 31, -2048));
		foreach (directed[i]) send_instr(directed[i]);

		// Random part, phase by phase: no idling, a long receiver hold-off while the
		// sender keeps going, then sender idling, receiver stalling, and both together.
		run_random(PHASE_ITEMS);
		hold_req = 1'b1;
		run_random(PHASE_ITEMS);
		send_idle_pct = 58;
		run_random(PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 58;
		run_random(PHASE_ITEMS);
		send_idle_pct  = 26;
		recv_stall_pct = 26;
		run_random(PHASE_ITEMS);

		// Halt last, and show that every later beat only reports the halt.
		send_instr(make_instr(OP_ECALL, 5, 6, 7, 0));
		send_instr(random_instr());
		send_instr(make_instr(OP_INVALID, 1, 2, 3, 0));
		send_instr(make_instr(OP_JAL, 9, 0, 0, 0));
		instr_bus.valid <= 1'b0;

		while (predictor.pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (predictor.errors == 0)
			$display("rv32_subset_instruction_step_core regression: pass");
		else
			$display("rv32_subset_instruction_step_core regression: fail");
		$finish;
	end

endmodule

### rv32_subset_instruction_step_core.f
hdl/rv32s_pkg.sv
hdl/rv32s_instr_if.sv
hdl/rv32s_result_if.sv
hdl/rv32_subset_instruction_step_core.sv
dv/rv32_subset_instruction_step_core_tb.sv
